/* rtl/sps_pkg.sv */
// Package with payload types, command codes, phase tables and rotate constants.
package sps_pkg;

    localparam int STEPS_PER_TURN = 200;
    localparam int DEG_PER_TURN   = 360;

    localparam int ROT_NUM_W   = 16 + $clog2(STEPS_PER_TURN);
    localparam int ROT_SHIFT   = ROT_NUM_W + 9;
    localparam int ROT_RECIP_W = ROT_SHIFT - 8;
    localparam int ROT_PROD_W  = ROT_NUM_W + ROT_RECIP_W;
    localparam int ROT_Q_W     = ROT_NUM_W - 8;
    localparam longint ROT_RECIP =
        ((64'd1 << ROT_SHIFT) + DEG_PER_TURN - 1) / DEG_PER_TURN;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_FWD     = 3'd1;
    localparam logic [2:0] CMD_BACK    = 3'd2;
    localparam logic [2:0] CMD_MOVE    = 3'd3;
    localparam logic [2:0] CMD_ROTATE  = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;
    localparam logic [2:0] CMD_HOME    = 3'd6;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [23:0] step_count;
        logic signed [15:0] angle_degrees;
        logic [15:0]        delay_ticks;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         coil_drive;
        logic signed [31:0] step_position;
        logic               moving;
        logic               stepped;
    } out_item_t;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [23:0]          step_count;
        logic                 rot_neg;
        logic [ROT_NUM_W-1:0] rot_num;
        logic [15:0]          delay_ticks;
    } staged_item_t;

    function automatic logic [3:0] full_pattern(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'b0011;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b1100;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

    function automatic logic [3:0] half_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/sps_in_stage.sv */
// Input register stage that also scales the rotate angle by the steps per turn.
module sps_in_stage import sps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_item,
    input  logic         take,
    output logic         item_valid,
    output staged_item_t item
);

    logic         valid_reg;
    staged_item_t item_reg;
    staged_item_t item_next;
    logic [15:0]  ang_mag;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        ang_mag = s_item.angle_degrees[15] ? (~s_item.angle_degrees + 16'd1)
                                           : s_item.angle_degrees;
        item_next.cmd         = s_item.cmd;
        item_next.step_count  = s_item.step_count;
        item_next.rot_neg     = s_item.angle_degrees[15];
        item_next.rot_num     = ROT_NUM_W'(ang_mag) * ROT_NUM_W'(STEPS_PER_TURN);
        item_next.delay_ticks = s_item.delay_ticks;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/sps_core.sv */
// Sequencer state, step and move logic, and the result register.
module sps_core import sps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  staged_item_t item,
    output logic         take,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_item
);

    logic                  half_mode_reg;
    logic [2:0]            phase_reg, phase_next;
    logic [31:0]           pos_reg, pos_next;
    logic [23:0]           steps_reg, steps_next;
    logic [15:0]           delay_reg, delay_next;
    logic [15:0]           reload_reg, reload_next;
    logic                  back_reg, back_next;
    logic [3:0]            coil_reg, coil_next;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    logic [ROT_PROD_W-1:0] rot_prod;
    logic [ROT_Q_W-1:0]    rot_quot;
    logic [23:0]           rot_mag;
    logic                  rot_back;
    logic [23:0]           mv_mag;
    logic                  mv_back;
    logic                  do_step;
    logic                  dir_back;
    logic [2:0]            mask;
    logic                  stepped;

    assign take    = item_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        rot_prod = ROT_PROD_W'(item.rot_num) * ROT_PROD_W'(ROT_RECIP);
        rot_quot = rot_prod[ROT_SHIFT +: ROT_Q_W];
        rot_mag  = half_mode_reg ? 24'({rot_quot, 1'b0}) : 24'(rot_quot);
        rot_back = item.rot_neg && (rot_quot != '0);
        mask     = half_mode_reg ? 3'd7 : 3'd3;

        if (item.cmd == CMD_ROTATE) begin
            mv_mag  = rot_mag;
            mv_back = rot_back;
        end else begin
            mv_mag  = item.step_count[23] ? (~item.step_count + 24'd1) : item.step_count;
            mv_back = item.step_count[23];
        end

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        steps_next  = steps_reg;
        delay_next  = delay_reg;
        reload_next = reload_reg;
        back_next   = back_reg;
        coil_next   = coil_reg;
        do_step     = 1'b0;
        dir_back    = 1'b0;

        case (item.cmd)
            CMD_TICK: begin
                if (delay_reg != 16'd0) begin
                    delay_next = delay_reg - 16'd1;
                end else if (steps_reg != 24'd0) begin
                    do_step    = 1'b1;
                    dir_back   = back_reg;
                    steps_next = steps_reg - 24'd1;
                    delay_next = reload_reg;
                end
            end
            CMD_FWD: begin
                do_step = 1'b1;
            end
            CMD_BACK: begin
                do_step  = 1'b1;
                dir_back = 1'b1;
            end
            CMD_MOVE, CMD_ROTATE: begin
                back_next   = mv_back;
                reload_next = item.delay_ticks;
                if (mv_mag != 24'd0) begin
                    do_step    = 1'b1;
                    dir_back   = mv_back;
                    steps_next = mv_mag - 24'd1;
                    delay_next = item.delay_ticks;
                end else begin
                    steps_next = 24'd0;
                    delay_next = 16'd0;
                end
            end
            CMD_RELEASE: begin
                coil_next  = 4'd0;
                steps_next = 24'd0;
                delay_next = 16'd0;
            end
            CMD_HOME: begin
                pos_next = 32'd0;
            end
            default: begin
            end
        endcase

        if (do_step) begin
            phase_next = dir_back ? ((phase_reg + mask) & mask)
                                  : ((phase_reg + 3'd1) & mask);
            pos_next   = dir_back ? (pos_reg - 32'd1) : (pos_reg + 32'd1);
            coil_next  = half_mode_reg ? half_pattern(phase_next)
                                       : full_pattern(phase_next[1:0]);
        end
        stepped = do_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_mode_reg <= 1'b0;
            phase_reg     <= 3'd0;
            pos_reg       <= 32'd0;
            steps_reg     <= 24'd0;
            delay_reg     <= 16'd0;
            reload_reg    <= 16'd0;
            back_reg      <= 1'b0;
            coil_reg      <= 4'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (take) begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                steps_reg   <= steps_next;
                delay_reg   <= delay_next;
                reload_reg  <= reload_next;
                back_reg    <= back_next;
                coil_reg    <= coil_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                half_mode_reg <= cfg_wr_data;
                phase_reg     <= 3'd0;
            end
        end
        if (take) begin
            m_item_reg.coil_drive    <= coil_next;
            m_item_reg.step_position <= pos_next;
            m_item_reg.moving        <= (steps_next != 24'd0) || (delay_next != 16'd0);
            m_item_reg.stepped       <= stepped;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("Result register did not load after a transfer into the core.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.stepped |-> m_item_reg.coil_drive != 4'd0)
        else $error("A step produced an empty coil pattern.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !half_mode_reg |-> phase_reg[2] == 1'b0)
        else $error("Phase index out of range in full-step mode.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(take) && m_item_reg.stepped |->
            (m_item_reg.step_position == $past(pos_reg) + 32'd1) ||
            (m_item_reg.step_position == $past(pos_reg) - 32'd1))
        else $error("A step moved the position by more than one.");

endmodule

/* rtl/stepper_phase_sequencer.sv */
// Top level of the stepper coil phase sequencer.
// Each transfer on the s_ channel is one command (tick, step forward or back, move, rotate,
// release, home) and gives exactly one result transfer on the m_ channel with the coil
// pattern, the signed position, the moving flag and the stepped flag. The block takes one
// command per clock cycle while m_ready stays high; each command is held in an input
// register and then a result register before its result appears, so back-to-back commands
// stream through both registers at full rate. Rotate converts degrees to steps as
// degrees * 200 / 360 truncated toward zero, doubled in half-step mode. Writing the mode
// register through cfg_wr_en and cfg_wr_data selects full-step (0) or half-step (1) and
// clears the phase index; write it only while no command is in flight.
module stepper_phase_sequencer import sps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    logic         item_valid;
    logic         take;
    staged_item_t item;

    sps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sps_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

/* tb/sps_checker.sv */
// Checker that predicts the coil sequencer results and compares every result transfer.
`timescale 1ns / 100ps

module sps_checker import sps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        pending_results,
    output int        mismatch_count
);

    localparam logic [15:0] FULL_SEQ = {4'b1001, 4'b1100, 4'b0110, 4'b0011};
    localparam logic [31:0] HALF_SEQ = {4'b1001, 4'b1000, 4'b1100, 4'b0100,
                                        4'b0110, 4'b0010, 4'b0011, 4'b0001};

    logic        half_mode;
    logic [2:0]  phase_idx;
    logic [31:0] position;
    logic [23:0] steps_remaining;
    logic [15:0] ticks_remaining;
    logic [15:0] tick_reload;
    logic        going_back;
    logic [3:0]  coil_bits;

    out_item_t   coil_state_q[$];

    function automatic void move_one_step(input logic backward);
        logic [2:0] mask;
        mask = half_mode ? 3'd7 : 3'd3;
        if (backward) begin
            phase_idx = (phase_idx + mask) & mask;
            position  = position - 32'd1;
        end else begin
            phase_idx = (phase_idx + 3'd1) & mask;
            position  = position + 32'd1;
        end
        coil_bits = half_mode ? HALF_SEQ[{phase_idx, 2'b00} +: 4]
                              : FULL_SEQ[{phase_idx[1:0], 2'b00} +: 4];
    endfunction

    function automatic logic pace_move();
        if (ticks_remaining != 16'd0) begin
            ticks_remaining = ticks_remaining - 16'd1;
            return 1'b0;
        end
        if (steps_remaining != 24'd0) begin
            move_one_step(going_back);
            steps_remaining = steps_remaining - 24'd1;
            ticks_remaining = tick_reload;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic out_item_t next_coil_state(input in_item_t it);
        out_item_t   res;
        int          count;
        logic [31:0] mag;
        logic        did_step;
        did_step = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                did_step = pace_move();
            end
            CMD_FWD: begin
                move_one_step(1'b0);
                did_step = 1'b1;
            end
            CMD_BACK: begin
                move_one_step(1'b1);
                did_step = 1'b1;
            end
            CMD_MOVE, CMD_ROTATE: begin
                if (it.cmd == CMD_MOVE) begin
                    count = int'(it.step_count);
                end else begin
                    count = (int'(it.angle_degrees) * STEPS_PER_TURN) / DEG_PER_TURN;
                    if (half_mode) begin
                        count = count * 2;
                    end
                end
                going_back      = (count < 0);
                mag             = going_back ? -count : count;
                steps_remaining = mag[23:0];
                tick_reload     = it.delay_ticks;
                ticks_remaining = 16'd0;
                did_step        = pace_move();
            end
            CMD_RELEASE: begin
                coil_bits       = 4'd0;
                steps_remaining = 24'd0;
                ticks_remaining = 16'd0;
            end
            CMD_HOME: begin
                position = 32'd0;
            end
            default: begin
            end
        endcase
        res.coil_drive    = coil_bits;
        res.step_position = position;
        res.moving        = (steps_remaining != 24'd0) || (ticks_remaining != 16'd0);
        res.stepped       = did_step;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        int        pushed;
        int        popped;
        pushed = 0;
        popped = 0;
        if (!aresetn) begin
            half_mode       = 1'b0;
            phase_idx       = 3'd0;
            position        = 32'd0;
            steps_remaining = 24'd0;
            ticks_remaining = 16'd0;
            tick_reload     = 16'd0;
            going_back      = 1'b0;
            coil_bits       = 4'd0;
            coil_state_q.delete();
            pending_results <= 0;
            mismatch_count  <= 0;
        end else begin
            if (cfg_wr_en) begin
                half_mode = cfg_wr_data;
                phase_idx = 3'd0;
            end
            if (s_valid && s_ready) begin
                coil_state_q.push_back(next_coil_state(s_item));
                pushed = 1;
            end
            if (m_valid && m_ready) begin
                if (coil_state_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result transfer with nothing expected: coil %b pos %0d"
                                 , $realtime, m_item.coil_drive, m_item.step_position);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want   = coil_state_q.pop_front();
                    popped = 1;
                    if (m_item.coil_drive !== want.coil_drive ||
                        m_item.step_position !== want.step_position ||
                        m_item.moving !== want.moving ||
                        m_item.stepped !== want.stepped) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: expected coil %b pos %0d moving %b stepped %b",
                                     $realtime, want.coil_drive, want.step_position,
                                     want.moving, want.stepped);
                            $display("%0t: actual   coil %b pos %0d moving %b stepped %b",
                                     $realtime, m_item.coil_drive, m_item.step_position,
                                     m_item.moving, m_item.stepped);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_results <= pending_results + pushed - popped;
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top that drives commands and mode writes into the stepper sequencer.
`timescale 1ns / 100ps

module tb_top;
    import sps_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    logic      cfg_wr_en;
    logic      cfg_wr_data;

    int        pending_results;
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        cmds_sent;
    int        mode_writes;
    int        stall_cycles;

    stepper_phase_sequencer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    sps_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer.", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic drive_cmd(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        cmds_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_mode(input logic half);
        wait_drained();
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= half;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    function automatic in_item_t make_cmd(input logic [2:0] cmd, input int cnt,
                                          input int ang, input int dly);
        in_item_t it;
        it.cmd           = cmd;
        it.step_count    = cnt[23:0];
        it.angle_degrees = ang[15:0];
        it.delay_ticks   = dly[15:0];
        return it;
    endfunction

    function automatic in_item_t random_cmd();
        in_item_t    it;
        logic [63:0] raw;
        int          pick;
        int          cnt;
        raw  = {$urandom(), $urandom()};
        it   = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.cmd = CMD_TICK;
        end else if (pick < 53) begin
            it.cmd = CMD_FWD;
        end else if (pick < 60) begin
            it.cmd = CMD_BACK;
        end else if (pick < 75) begin
            it.cmd = CMD_MOVE;
        end else if (pick < 85) begin
            it.cmd = CMD_ROTATE;
        end else if (pick < 90) begin
            it.cmd = CMD_RELEASE;
        end else begin
            it.cmd = CMD_HOME;
        end
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            cnt = $urandom_range(0, 12);
        end else begin
            cnt = $urandom_range(0, 200);
        end
        if ($urandom_range(0, 1) == 1) begin
            cnt = -cnt;
        end
        if (pick < 95) begin
            it.step_count = cnt[23:0];
        end
        if ($urandom_range(0, 99) < 70) begin
            cnt = $urandom_range(0, 720);
            if ($urandom_range(0, 1) == 1) begin
                cnt = -cnt;
            end
            it.angle_degrees = cnt[15:0];
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.delay_ticks = $urandom_range(0, 3);
        end else if (pick < 95) begin
            it.delay_ticks = $urandom_range(0, 20);
        end
        return it;
    endfunction

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_item        <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 83;
        cmds_sent     = 0;
        mode_writes   = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(1'b0);
        drive_cmd(make_cmd(CMD_FWD, 0, 0, 0));
        drive_cmd(make_cmd(CMD_FWD, 0, 0, 0));
        drive_cmd(make_cmd(CMD_BACK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_BACK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_BACK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_HOME, 0, 0, 0));
        drive_cmd(make_cmd(CMD_MOVE, 3, 0, 1));
        repeat (5) drive_cmd(make_cmd(CMD_TICK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_MOVE, -2, 0, 0));
        drive_cmd(make_cmd(CMD_TICK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_TICK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_ROTATE, 0, 360, 0));
        drive_cmd(make_cmd(CMD_RELEASE, 0, 0, 0));
        drive_cmd(make_cmd(CMD_ROTATE, 0, -1, 0));
        drive_cmd(make_cmd(CMD_ROTATE, 0, 32767, 65535));
        drive_cmd(make_cmd(CMD_TICK, 0, 0, 0));
        drive_cmd(make_cmd(CMD_ROTATE, 0, -32768, 2));
        drive_cmd(make_cmd(CMD_MOVE, -8388608, 0, 65535));
        drive_cmd(make_cmd(CMD_MOVE, 8388607, 0, 0));
        drive_cmd(make_cmd(CMD_RELEASE, 0, 0, 0));
        drive_cmd(make_cmd(CMD_TICK, 0, 0, 0));

        write_mode(1'b1);
        repeat (135) drive_cmd(random_cmd());
        wait_drained();
        repeat (135) drive_cmd(random_cmd());

        send_idle_pct = 83;
        recv_idle_pct = 32;
        write_mode(1'b0);
        repeat (270) drive_cmd(random_cmd());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'b1);
        repeat (130) drive_cmd(random_cmd());
        write_mode(1'b0);
        repeat (130) drive_cmd(random_cmd());

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d commands over %0d mode writes in full-step and half-step mode,",
                 cmds_sent, mode_writes);
        $display("with sender-heavy, receiver-heavy and gapless pacing of both channels.");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
